// File: src/bprq_pkg.sv
// Package for the bitmap priority ready queue: sizes, opcodes, payload structs, states, and a lowest-bit helper.
// No dependencies.
`default_nettype none
package bprq_pkg;

    localparam int NUM_PRIORITIES = 64;
    localparam int MAX_TASKS      = 64;

    typedef enum logic [1:0]
    {
        OP_ENQ  = 2'd0,
        OP_REM  = 2'd1,
        OP_PICK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    localparam logic [6:0] COUNT_MAX = 7'd127;

    typedef struct packed
    {
        logic [1:0] opcode;
        logic [5:0] task_id;
        logic [5:0] priority_req;
    } in_item_t;

    typedef struct packed
    {
        logic [5:0] picked_task;
        logic       picked_valid;
        logic [5:0] picked_priority;
        logic [6:0] ready_count;
    } out_item_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_WR,
        ST_OUT
    } state_t;

    // index of lowest set bit of a byte, 0 when none
    function automatic logic [2:0] lowest_bit(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/bitmap_priority_round_robin_queue.sv
// Bitmap priority ready queue, top level.
// Depends on bprq_pkg.
//
// One item is handled at a time. After acceptance the block steps through a state reading
// the head/tail tables (RD1), a state reading the link tables through their registered
// read port (RD2), a write-back state (WR), then the output register (OUT). A pick chooses
// its level from the bitmaps at acceptance. The block is back in idle when the result is
// offered; the next item is accepted once the previous result has been taken or together
// with it, and a result left waiting holds off input.
// Link and head/tail entries never written read as unknown. Picks on an empty queue
// return picked_valid low.
`default_nettype none
module bitmap_priority_round_robin_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  bprq_pkg::in_item_t    in_data,
    input  wire                   in_valid,
    output logic                  in_ready,
    output bprq_pkg::out_item_t   out_data,
    output logic                  out_valid,
    input  wire                   out_ready
);
    import bprq_pkg::*;

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PW = $clog2(NUM_PRIORITIES);

    // memories
    logic [TW-1:0] next_mem [MAX_TASKS];
    logic [TW-1:0] prev_mem [MAX_TASKS];
    logic [TW-1:0] head_mem [NUM_PRIORITIES];
    logic [TW-1:0] tail_mem [NUM_PRIORITIES];

    state_t state_reg, state_next;
    logic [7:0] rows_reg [8];
    logic [7:0] groups_reg;
    logic [6:0] total_reg;

    logic [1:0]    op_reg;
    logic [TW-1:0] t_reg;
    logic [PW-1:0] p_reg;
    logic          act_reg;     // operation touches lists
    logic          lvl_rdy_reg;
    logic [TW-1:0] hd_q, tl_q, nx_q, pv_q;
    logic [TW-1:0] hd_r, tl_r;
    out_item_t     out_reg;
    logic          out_valid_reg;

    logic accept;
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // capture and level selection
    logic [2:0] gy, rx;
    logic [5:0] lv;
    assign gy = lowest_bit(groups_reg);
    assign rx = lowest_bit(rows_reg[gy]);
    assign lv = {gy, rx};

    logic in_range;
    assign in_range = (32'(in_data.task_id) < MAX_TASKS)
                   && (32'(in_data.priority_req) < NUM_PRIORITIES);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_data.opcode;
            t_reg  <= in_data.task_id[TW-1:0];
            if (in_data.opcode == OP_PICK)
            begin
                p_reg   <= lv[PW-1:0];
                act_reg <= (groups_reg != 8'd0) && (32'(lv) < NUM_PRIORITIES);
                lvl_rdy_reg <= 1'b1;
            end
            else
            begin
                p_reg   <= in_data.priority_req[PW-1:0];
                act_reg <= in_range && (in_data.opcode != OP_NOP);
                lvl_rdy_reg <= rows_reg[in_data.priority_req[5:3]][in_data.priority_req[2:0]];
            end
        end
    end

    // head/tail read in RD1, link read in RD2
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD1)
        begin
            hd_q <= head_mem[p_reg];
            tl_q <= tail_mem[p_reg];
        end
    end

    logic [TW-1:0] link_addr;
    assign link_addr = (op_reg == OP_PICK) ? hd_q : t_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD2)
        begin
            nx_q <= next_mem[link_addr];
            pv_q <= prev_mem[link_addr];
            hd_r <= hd_q;
            tl_r <= tl_q;
        end
    end

    // write back
    logic wr;
    assign wr = (state_reg == ST_WR) && act_reg;
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            case (op_reg)
                OP_ENQ:
                begin
                    if (!lvl_rdy_reg)
                    begin
                        head_mem[p_reg] <= t_reg;
                    end
                    else
                    begin
                        next_mem[tl_r] <= t_reg;
                        prev_mem[t_reg] <= tl_r;
                    end
                    tail_mem[p_reg] <= t_reg;
                end
                OP_REM:
                begin
                    if (lvl_rdy_reg)
                    begin
                        if (hd_r == t_reg && tl_r == t_reg)
                        begin
                        end
                        else if (hd_r == t_reg)
                        begin
                            head_mem[p_reg] <= nx_q;
                        end
                        else if (tl_r == t_reg)
                        begin
                            tail_mem[p_reg] <= pv_q;
                        end
                        else
                        begin
                            next_mem[pv_q] <= nx_q;
                            prev_mem[nx_q] <= pv_q;
                        end
                    end
                end
                OP_PICK:
                begin
                    if (hd_r != tl_r)
                    begin
                        head_mem[p_reg] <= nx_q;
                        next_mem[tl_r] <= hd_r;
                        prev_mem[hd_r] <= tl_r;
                        tail_mem[p_reg] <= hd_r;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // bitmaps and count
    logic [7:0] row_clr;
    assign row_clr = rows_reg[p_reg[5:3]] & ~(8'd1 << p_reg[2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                rows_reg[i] <= 8'd0;
            end
            groups_reg <= 8'd0;
            total_reg  <= 7'd0;
        end
        else if (wr)
        begin
            if (op_reg == OP_ENQ)
            begin
                rows_reg[p_reg[5:3]] <= rows_reg[p_reg[5:3]] | (8'd1 << p_reg[2:0]);
                groups_reg <= groups_reg | (8'd1 << p_reg[5:3]);
                if (total_reg != COUNT_MAX)
                begin
                    total_reg <= total_reg + 7'd1;
                end
            end
            else if (op_reg == OP_REM)
            begin
                if (total_reg != 7'd0)
                begin
                    total_reg <= total_reg - 7'd1;
                end
                if (lvl_rdy_reg && hd_r == t_reg && tl_r == t_reg)
                begin
                    rows_reg[p_reg[5:3]] <= row_clr;
                    if (row_clr == 8'd0)
                    begin
                        groups_reg <= groups_reg & ~(8'd1 << p_reg[5:3]);
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            out_reg.ready_count <= total_reg;
            if (op_reg == OP_PICK && act_reg)
            begin
                out_reg.picked_task     <= 6'(hd_r);
                out_reg.picked_valid    <= 1'b1;
                out_reg.picked_priority <= 6'(p_reg);
            end
            else
            begin
                out_reg.picked_task     <= 6'd0;
                out_reg.picked_valid    <= 1'b0;
                out_reg.picked_priority <= 6'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_WR;
            ST_WR:   state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: src/bprq_checker.sv
// Port-level checks for the bitmap priority ready queue, bound to the top level.
// Depends on bprq_pkg.
`default_nettype none
module bprq_checker (
    input wire                 clk,
    input wire                 rst_n,
    input bprq_pkg::in_item_t  in_data,
    input wire                 in_valid,
    input wire                 in_ready,
    input bprq_pkg::out_item_t out_data,
    input wire                 out_valid,
    input wire                 out_ready
);
    import bprq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input item changed while waiting");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.picked_valid |->
        out_data.picked_task == 6'd0 && out_data.picked_priority == 6'd0)
        else $error("picked fields not zero");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result offered straight after acceptance");

endmodule

bind bitmap_priority_round_robin_queue bprq_checker u_bprq_checker (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
    .in_ready(in_ready), .out_data(out_data), .out_valid(out_valid),
    .out_ready(out_ready)
);
`default_nettype wire
